/* rtl/cirs_pkg.sv */
// ----------------------------------------------------------------------------
// Chunked image receive sequencer package
// Command, status, failure and progress codes, register indexes, reset values
// and the divider status bundle shared by the sequencer, divider and checker.
// ----------------------------------------------------------------------------
package cirs_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 16;
  localparam int PCT_W   = 7;

  localparam int unsigned MIN_IMAGE_BYTES_DEF = 32768;

  localparam logic [DATA_W-1:0] CAPACITY_RESET    = 32'd1572864;
  localparam logic [DATA_W-1:0] PAUSE_LIMIT_RESET = 32'd86400;

  localparam logic [7:0] MAGIC_FIRST  = 8'h4F;
  localparam logic [7:0] MAGIC_SECOND = 8'h42;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_CAP   = 7'd99;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_ZERO  = 7'd0;

  localparam logic REG_CAPACITY    = 1'b0;
  localparam logic REG_PAUSE_LIMIT = 1'b1;

  localparam logic [2:0] CMD_BEGIN     = 3'd0;
  localparam logic [2:0] CMD_CHUNK     = 3'd1;
  localparam logic [2:0] CMD_ABORT     = 3'd2;
  localparam logic [2:0] CMD_LINK_LOST = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ARG   = 3'd1;
  localparam logic [2:0] ST_STATE = 3'd2;
  localparam logic [2:0] ST_SIZE  = 3'd3;
  localparam logic [2:0] ST_FAIL  = 3'd4;

  localparam logic [2:0] FAIL_NONE     = 3'd0;
  localparam logic [2:0] FAIL_HEADER   = 3'd1;
  localparam logic [2:0] FAIL_COUNT    = 3'd2;
  localparam logic [2:0] FAIL_ORDER    = 3'd3;
  localparam logic [2:0] FAIL_OVERFLOW = 3'd4;
  localparam logic [2:0] FAIL_LAST     = 3'd5;

  localparam logic [1:0] PROG_IDLE = 2'd0;
  localparam logic [1:0] PROG_DOWN = 2'd1;
  localparam logic [1:0] PROG_DONE = 2'd2;
  localparam logic [1:0] PROG_ERR  = 2'd3;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_stat_t;

endpackage

/* rtl/cirs_div.sv */
// ----------------------------------------------------------------------------
// Percentage divider
// Restoring divider for received * 100 / total, one quotient bit per cycle.
// The quotient never exceeds 100, so seven steps cover it.
// ----------------------------------------------------------------------------
module cirs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               dividend,
  input  logic [31:0]               divisor,
  output cirs_pkg::div_stat_t       stat
);
  import cirs_pkg::*;

  localparam int NUM_W  = DATA_W + PCT_W;
  localparam int STEP_W = $clog2(PCT_W);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-2:0]  dsh;
  logic [PCT_W-1:0]  quot;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [NUM_W-1:0]  dsh_ext;
  logic              ge;

  assign dsh_ext = {1'b0, dsh};
  assign ge      = rem >= dsh_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= NUM_W'(dividend) * NUM_W'(PCT_SCALE);
        dsh  <= {divisor, (PCT_W-1)'(0)};
        quot <= '0;
        step <= STEP_W'(PCT_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh_ext;
        end
        quot <= {quot[PCT_W-2:0], ge};
        dsh  <= dsh >> 1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

/* rtl/chunked_image_receive_sequencer.sv */
// ----------------------------------------------------------------------------
// Chunked image receive sequencer
// Session control for receiving a firmware image in numbered chunks: begin,
// chunk header checks, abort, link loss and pause timeout, with progress.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   cfg     | in        | cfg_we               | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready  | cmd .. payload_length
//   out     | out       | out_valid / out_ready| status .. failure_reason
//
// A chunk that leaves the image unfinished passes through S_START and the
// 7-step percentage divider before S_EMIT; every other transaction goes from
// S_IDLE straight to S_EMIT.
// One transaction at a time: in_ready is high only while the sequencer idles.
// A stalled result holds in the output register; the next transaction is
// taken meanwhile, and its result waits until the register frees.
// Reset (rst, synchronous) returns to no session and the register defaults.
// ----------------------------------------------------------------------------
module chunked_image_receive_sequencer #(
  parameter int unsigned MIN_IMAGE_BYTES = cirs_pkg::MIN_IMAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] image_size,
  input  logic [7:0]  magic_first,
  input  logic [7:0]  magic_second,
  input  logic [15:0] chunk_index,
  input  logic [15:0] chunk_count,
  input  logic [15:0] payload_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        accept_payload,
  output logic        image_complete,
  output logic        session_open,
  output logic        session_paused,
  output logic        receiving_now,
  output logic [31:0] bytes_received,
  output logic [31:0] image_total,
  output logic [15:0] expected_chunk,
  output logic [6:0]  percent_done,
  output logic [1:0]  progress_state,
  output logic [2:0]  failure_reason
);
  import cirs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_START, S_DIVIDE, S_EMIT} state_t;
  typedef enum logic [1:0] {LM_IDLE, LM_RX, LM_PAUSED} link_mode_t;

  state_t             state;
  link_mode_t         link_mode, link_mode_next;
  logic [DATA_W-1:0]  partition_capacity;
  logic [DATA_W-1:0]  pause_limit_ticks;
  logic [DATA_W-1:0]  received_count, received_count_next;
  logic [DATA_W-1:0]  expected_total, expected_total_next;
  logic [INDEX_W-1:0] expected_index, expected_index_next;
  logic [INDEX_W-1:0] announced_count, announced_count_next;
  logic               count_known, count_known_next;
  logic [PCT_W-1:0]   progress_percent, progress_percent_next;
  logic [1:0]         progress_mode, progress_mode_next;
  logic [2:0]         last_failure, last_failure_next;
  logic [DATA_W-1:0]  pause_ticks, pause_ticks_next;
  logic [2:0]         res_status, res_status_next;
  logic               res_accept, res_accept_next;
  logic               res_complete, res_complete_next;
  logic               div_need_next;

  logic               do_fail, do_abort;
  logic [2:0]         fail_code;
  logic [DATA_W:0]    sum;
  logic [DATA_W-1:0]  tick_count;
  link_mode_t         mode_now;
  logic               open_now;
  div_stat_t          div_stat;

  assign in_ready = (state == S_IDLE);
  assign sum      = {1'b0, received_count} + (DATA_W+1)'(payload_length);
  assign open_now = (link_mode == LM_RX) || (link_mode == LM_PAUSED);

  cirs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (received_count),
    .divisor  (expected_total),
    .stat     (div_stat)
  );

  always_comb begin
    link_mode_next        = link_mode;
    received_count_next   = received_count;
    expected_total_next   = expected_total;
    expected_index_next   = expected_index;
    announced_count_next  = announced_count;
    count_known_next      = count_known;
    progress_percent_next = progress_percent;
    progress_mode_next    = progress_mode;
    last_failure_next     = last_failure;
    pause_ticks_next      = pause_ticks;
    res_status_next       = ST_OK;
    res_accept_next       = 1'b0;
    res_complete_next     = 1'b0;
    div_need_next         = 1'b0;
    do_fail               = 1'b0;
    do_abort              = 1'b0;
    fail_code             = FAIL_NONE;
    mode_now              = link_mode;
    tick_count            = (pause_ticks == '1) ? pause_ticks : pause_ticks + 1'b1;

    case (cmd)
      CMD_BEGIN: begin
        if (link_mode != LM_IDLE) begin
          res_status_next = ST_STATE;
        end else if (image_size < DATA_W'(MIN_IMAGE_BYTES)) begin
          res_status_next = ST_ARG;
        end else if (image_size > partition_capacity) begin
          res_status_next = ST_SIZE;
        end else begin
          link_mode_next        = LM_RX;
          count_known_next      = 1'b0;
          expected_index_next   = '0;
          received_count_next   = '0;
          pause_ticks_next      = '0;
          expected_total_next   = image_size;
          announced_count_next  = '0;
          progress_mode_next    = PROG_DOWN;
          progress_percent_next = PCT_ZERO;
          last_failure_next     = FAIL_NONE;
        end
      end
      CMD_CHUNK: begin
        if (payload_length == '0 || magic_first != MAGIC_FIRST ||
            magic_second != MAGIC_SECOND) begin
          res_status_next = ST_ARG;
        end else begin
          if (link_mode == LM_PAUSED) begin
            mode_now         = LM_RX;
            link_mode_next   = LM_RX;
            pause_ticks_next = '0;
          end
          if (mode_now != LM_RX) begin
            res_status_next = ST_STATE;
          end else if (chunk_count == '0 || chunk_index >= chunk_count) begin
            do_fail         = 1'b1;
            fail_code       = FAIL_HEADER;
            res_status_next = ST_ARG;
          end else begin
            if (chunk_index == '0) begin
              announced_count_next = chunk_count;
              count_known_next     = 1'b1;
            end
            if (chunk_index != '0 && !count_known) begin
              res_status_next = ST_STATE;
            end else if (chunk_index != '0 && chunk_count != announced_count) begin
              do_fail         = 1'b1;
              fail_code       = FAIL_COUNT;
              res_status_next = ST_STATE;
            end else if (chunk_index != expected_index) begin
              do_fail         = 1'b1;
              fail_code       = FAIL_ORDER;
              res_status_next = ST_STATE;
            end else if (sum > {1'b0, expected_total}) begin
              do_fail         = 1'b1;
              fail_code       = FAIL_OVERFLOW;
              res_status_next = ST_SIZE;
            end else begin
              res_accept_next     = 1'b1;
              received_count_next = sum[DATA_W-1:0];
              expected_index_next = expected_index + 1'b1;
              if (sum[DATA_W-1:0] == expected_total) begin
                if (chunk_index != chunk_count - 1'b1) begin
                  do_fail         = 1'b1;
                  fail_code       = FAIL_LAST;
                  res_status_next = ST_FAIL;
                end else begin
                  link_mode_next        = LM_IDLE;
                  count_known_next      = 1'b0;
                  progress_percent_next = PCT_FULL;
                  progress_mode_next    = PROG_DONE;
                  res_complete_next     = 1'b1;
                end
              end else begin
                div_need_next = 1'b1;
              end
            end
          end
        end
      end
      CMD_ABORT: begin
        if (open_now) begin
          do_abort = 1'b1;
        end else begin
          res_status_next = ST_STATE;
        end
      end
      CMD_LINK_LOST: begin
        if (link_mode == LM_RX) begin
          link_mode_next   = LM_PAUSED;
          pause_ticks_next = '0;
        end
      end
      CMD_TICK: begin
        if (link_mode == LM_PAUSED) begin
          pause_ticks_next = tick_count;
          if (tick_count >= pause_limit_ticks) begin
            do_abort = 1'b1;
          end
        end
      end
      default: begin
        res_status_next = ST_ARG;
      end
    endcase

    if (do_fail || do_abort) begin
      link_mode_next      = LM_IDLE;
      count_known_next    = 1'b0;
      expected_index_next = '0;
      received_count_next = '0;
      expected_total_next = '0;
      pause_ticks_next    = '0;
    end
    if (do_fail) begin
      progress_mode_next = PROG_ERR;
      last_failure_next  = fail_code;
    end
    if (do_abort) begin
      progress_mode_next    = PROG_IDLE;
      progress_percent_next = PCT_ZERO;
      last_failure_next     = FAIL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      partition_capacity <= CAPACITY_RESET;
      pause_limit_ticks  <= PAUSE_LIMIT_RESET;
      link_mode          <= LM_IDLE;
      received_count     <= '0;
      expected_total     <= '0;
      expected_index     <= '0;
      announced_count    <= '0;
      count_known        <= 1'b0;
      progress_percent   <= PCT_ZERO;
      progress_mode      <= PROG_IDLE;
      last_failure       <= FAIL_NONE;
      pause_ticks        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY:    partition_capacity <= cfg_data;
          REG_PAUSE_LIMIT: pause_limit_ticks  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            link_mode        <= link_mode_next;
            received_count   <= received_count_next;
            expected_total   <= expected_total_next;
            expected_index   <= expected_index_next;
            announced_count  <= announced_count_next;
            count_known      <= count_known_next;
            progress_percent <= progress_percent_next;
            progress_mode    <= progress_mode_next;
            last_failure     <= last_failure_next;
            pause_ticks      <= pause_ticks_next;
            res_status       <= res_status_next;
            res_accept       <= res_accept_next;
            res_complete     <= res_complete_next;
            state            <= div_need_next ? S_START : S_EMIT;
          end
        end
        S_START: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_stat.done) begin
            progress_percent <= (div_stat.quot > PCT_CAP) ? PCT_CAP : div_stat.quot;
            state            <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            accept_payload <= res_accept;
            image_complete <= res_complete;
            session_open   <= open_now;
            session_paused <= (link_mode == LM_PAUSED);
            receiving_now  <= (link_mode == LM_RX);
            bytes_received <= open_now ? received_count : '0;
            image_total    <= open_now ? expected_total : '0;
            expected_chunk <= open_now ? expected_index : '0;
            if (open_now) begin
              percent_done <= (progress_percent > PCT_CAP) ? PCT_CAP : progress_percent;
            end else begin
              percent_done <= (progress_mode == PROG_DONE) ? PCT_FULL : PCT_ZERO;
            end
            progress_state <= progress_mode;
            failure_reason <= last_failure;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/cirs_checker.sv */
// ----------------------------------------------------------------------------
// Chunked image receive sequencer checker
// Port-level assertions on result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module cirs_port_props (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        accept_payload,
  input logic        image_complete,
  input logic        session_open,
  input logic        session_paused,
  input logic        receiving_now,
  input logic [31:0] bytes_received,
  input logic [31:0] image_total,
  input logic [15:0] expected_chunk,
  input logic [6:0]  percent_done,
  input logic [1:0]  progress_state
);
  import cirs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(bytes_received))
    else $error("result transaction changed while stalled");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (session_open == (session_paused || receiving_now)) &&
                  !(session_paused && receiving_now))
    else $error("link mode flags inconsistent");

  a_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !session_open |->
      bytes_received == '0 && image_total == '0 && expected_chunk == '0)
    else $error("counters nonzero with no session");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_complete |->
      accept_payload && status == ST_OK && percent_done == PCT_FULL &&
      progress_state == PROG_DONE && !session_open)
    else $error("completion result inconsistent");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && session_open |-> percent_done <= PCT_CAP &&
                                  bytes_received <= image_total)
    else $error("open session progress out of range");

endmodule

bind chunked_image_receive_sequencer cirs_port_props u_cirs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .accept_payload (accept_payload),
  .image_complete (image_complete),
  .session_open   (session_open),
  .session_paused (session_paused),
  .receiving_now  (receiving_now),
  .bytes_received (bytes_received),
  .image_total    (image_total),
  .expected_chunk (expected_chunk),
  .percent_done   (percent_done),
  .progress_state (progress_state)
);
